/* rtl/bgr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared sizes, types and the 5x7 column font for the band glyph rasterizer.
// ----------------------------------------------------------------------------
package bgr_pkg;

  // Band geometry
  localparam int BAND_WIDTH  = 240;
  localparam int BAND_ROWS   = 24;
  localparam int MAX_SCALE   = 15;
  localparam int STORE_DEPTH = BAND_WIDTH * BAND_ROWS;

  // Font geometry
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_W    = GLYPH_COLS * 8;

  // Derived widths
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int COL_W   = $clog2(BAND_WIDTH + 1);
  localparam int ROW_W   = $clog2(BAND_ROWS + 1);
  localparam int OFF_W   = $clog2(MAX_SCALE * (GLYPH_COLS - 1) + MAX_SCALE + 1);
  localparam int COORD_W = 13;
  localparam int PIX_W   = 16;

  // Write request into the band memory
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } mem_wr_t;

  // Font lookup: column 0 in the top byte, bit r of a column is glyph row r.
  // Unknown codes and space come back blank.
  function automatic logic [GLYPH_W-1:0] font_glyph(input logic [7:0] code);
    logic [GLYPH_W-1:0] g;
    case (code)
      8'h41:   g = {8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e}; // A
      8'h42:   g = {8'h7f, 8'h49, 8'h49, 8'h49, 8'h36}; // B
      8'h43:   g = {8'h3e, 8'h41, 8'h41, 8'h41, 8'h22}; // C
      8'h44:   g = {8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c}; // D
      8'h45:   g = {8'h7f, 8'h49, 8'h49, 8'h49, 8'h41}; // E
      8'h48:   g = {8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f}; // H
      8'h49:   g = {8'h00, 8'h41, 8'h7f, 8'h41, 8'h00}; // I
      8'h4c:   g = {8'h7f, 8'h40, 8'h40, 8'h40, 8'h40}; // L
      8'h4d:   g = {8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f}; // M
      8'h4e:   g = {8'h7f, 8'h02, 8'h0c, 8'h10, 8'h7f}; // N
      8'h4f:   g = {8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e}; // O
      8'h50:   g = {8'h7f, 8'h09, 8'h09, 8'h09, 8'h06}; // P
      8'h52:   g = {8'h7f, 8'h09, 8'h19, 8'h29, 8'h46}; // R
      8'h53:   g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31}; // S
      8'h54:   g = {8'h01, 8'h01, 8'h7f, 8'h01, 8'h01}; // T
      8'h55:   g = {8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f}; // U
      8'h59:   g = {8'h03, 8'h04, 8'h78, 8'h04, 8'h03}; // Y
      8'h5a:   g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43}; // Z
      8'h61:   g = {8'h20, 8'h54, 8'h54, 8'h54, 8'h78}; // a
      8'h62:   g = {8'h7f, 8'h48, 8'h44, 8'h44, 8'h38}; // b
      8'h63:   g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h20}; // c
      8'h64:   g = {8'h38, 8'h44, 8'h44, 8'h48, 8'h7f}; // d
      8'h65:   g = {8'h38, 8'h54, 8'h54, 8'h54, 8'h18}; // e
      8'h68:   g = {8'h7f, 8'h08, 8'h04, 8'h04, 8'h78}; // h
      8'h69:   g = {8'h00, 8'h44, 8'h7d, 8'h40, 8'h00}; // i
      8'h6c:   g = {8'h00, 8'h41, 8'h7f, 8'h40, 8'h00}; // l
      8'h6d:   g = {8'h7c, 8'h04, 8'h18, 8'h04, 8'h78}; // m
      8'h6e:   g = {8'h7c, 8'h08, 8'h04, 8'h04, 8'h78}; // n
      8'h6f:   g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38}; // o
      8'h70:   g = {8'h7c, 8'h14, 8'h14, 8'h14, 8'h08}; // p
      8'h72:   g = {8'h7c, 8'h08, 8'h04, 8'h04, 8'h08}; // r
      8'h73:   g = {8'h48, 8'h54, 8'h54, 8'h54, 8'h20}; // s
      8'h74:   g = {8'h04, 8'h3f, 8'h44, 8'h40, 8'h20}; // t
      8'h79:   g = {8'h0c, 8'h50, 8'h50, 8'h50, 8'h3c}; // y
      8'h7a:   g = {8'h44, 8'h64, 8'h54, 8'h4c, 8'h44}; // z
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

/* rtl/bgr_band_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_band_mem
// Band pixel store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bgr_band_mem
  import bgr_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_wr_t           wr,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] store [STORE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr.addr] <= wr.data;
    end
  end

  // Read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/band_glyph_rect_rasterizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// band_glyph_rect_rasterizer
// Band frame store with fill, clipped rectangle, scaled glyph and pixel read.
// ----------------------------------------------------------------------------
// Read path: a pixel read issues its memory read in S_READ and loads the
//   output register in S_RDATA when out_stall allows, raising out_valid.
// Throughput: one pixel write per cycle through the memory write port; a box
//   first passes the setup states S_CLIP and S_START, then sweeps its clipped
//   area; a band fill sweeps the whole band; a glyph visits each dot in S_DOT
//   and paints each lit dot's box. One request at a time, taken in S_IDLE.
// Reset: clears control state and band_top; pixel contents stay undefined
//   until written, there is no clearing pass.
// ----------------------------------------------------------------------------
module band_glyph_rect_rasterizer
  import bgr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [9:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           cmd,
  input  wire logic signed [10:0]   x_pos,
  input  wire logic signed [10:0]   y_pos,
  input  wire logic [9:0]           rect_width,
  input  wire logic [9:0]           rect_height,
  input  wire logic [7:0]           char_code,
  input  wire logic [3:0]           dot_scale,
  input  wire logic [15:0]          draw_color,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [15:0]               pixel_color,
  output logic                      in_band
);

  // Command codes
  localparam logic [1:0] CMD_FILL = 2'd0;
  localparam logic [1:0] CMD_RECT = 2'd1;
  localparam logic [1:0] CMD_CHAR = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLIP  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DOT   = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_RDATA = 3'd6;

  localparam logic signed [COORD_W-1:0] WIDTH_S = COORD_W'(BAND_WIDTH);
  localparam logic signed [COORD_W-1:0] ROWS_S  = COORD_W'(BAND_ROWS);
  localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
  localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

  logic [9:0] band_top;
  logic [2:0] state;
  logic [2:0] ret_state;

  // Latched request fields
  logic signed [10:0] px;
  logic signed [10:0] py;
  logic [3:0]         scale;
  logic [GLYPH_W-1:0] glyph;
  logic [PIX_W-1:0]   color;

  // Box to paint and its clipped bounds
  logic signed [COORD_W-1:0] box_left, box_top, box_w, box_h;
  logic signed [COORD_W-1:0] clip_t, clip_b, clip_l, clip_r;

  // Sweep counters
  logic [COL_W-1:0]  col, col_start, col_end;
  logic [ROW_W-1:0]  row, row_end;
  logic [ADDR_W-1:0] base;

  // Glyph dot walk
  logic [2:0]       dot_col, dot_row;
  logic [OFF_W-1:0] col_off, row_off;

  logic              req_take;
  logic [3:0]        scale_sat;
  logic signed [COORD_W-1:0] btop_s, bend_s;
  logic signed [COORD_W-1:0] box_b, box_r, rel_t, rel_b, rel_y;
  logic [5:0]        dot_idx;
  logic              dot_lit, dot_last, read_inside;
  logic [ROW_W-1:0]  start_row;
  mem_wr_t           wr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;
  logic              rd_inside;

  assign in_stall = (state != S_IDLE);
  assign req_take = in_valid && !in_stall;
  assign scale_sat = (dot_scale > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : dot_scale;

  assign btop_s = COORD_W'(band_top);
  assign bend_s = btop_s + ROWS_S;
  assign box_b  = box_top + box_h;
  assign box_r  = box_left + box_w;
  assign rel_t  = clip_t - btop_s;
  assign rel_b  = clip_b - btop_s;
  assign start_row = rel_t[ROW_W-1:0];

  // Glyph bit for the current dot
  assign dot_idx  = 6'(8 * (LAST_COL - dot_col)) + 6'(dot_row);
  assign dot_lit  = glyph[dot_idx];
  assign dot_last = (dot_col == LAST_COL) && (dot_row == LAST_ROW);

  // Read position
  assign rel_y = COORD_W'(py) - btop_s;
  assign read_inside = (px >= 11'sd0) && (COORD_W'(px) < WIDTH_S) &&
                       (COORD_W'(py) >= btop_s) && (COORD_W'(py) < bend_s);
  assign rd_en   = (state == S_READ) && read_inside;
  assign rd_addr = ADDR_W'(rel_y[ROW_W-1:0] * BAND_WIDTH) + ADDR_W'(px);

  // Memory write from the sweep
  assign wr.en   = (state == S_RUN);
  assign wr.addr = base + ADDR_W'(col);
  assign wr.data = color;

  bgr_band_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      band_top <= '0;
    end else if (cfg_write) begin
      band_top <= cfg_data;
    end
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_take) begin
            ret_state <= S_IDLE;
            case (cmd)
              CMD_FILL: state <= S_CLIP;
              CMD_RECT: state <= S_CLIP;
              CMD_CHAR: state <= (scale_sat == 4'd0) ? S_IDLE : S_DOT;
              CMD_READ: state <= S_READ;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_CLIP: state <= S_START;
        S_START: begin
          if ((clip_t >= clip_b) || (clip_l >= clip_r)) begin
            state <= ret_state;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if ((col == col_end - COL_W'(1)) && (row == row_end - ROW_W'(1))) begin
            state <= ret_state;
          end
        end
        S_DOT: begin
          ret_state <= dot_last ? S_IDLE : S_DOT;
          if (dot_lit) begin
            state <= S_CLIP;
          end else if (dot_last) begin
            state <= S_IDLE;
          end
        end
        S_READ:  state <= S_RDATA;
        S_RDATA: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request latch, box setup and dot walk
  always_ff @(posedge clk) begin
    if (req_take) begin
      px    <= x_pos;
      py    <= y_pos;
      scale <= scale_sat;
      glyph <= font_glyph(char_code);
      color <= draw_color;
      dot_col <= '0;
      dot_row <= '0;
      col_off <= '0;
      row_off <= '0;
      if (cmd == CMD_FILL) begin
        box_left <= '0;
        box_top  <= btop_s;
        box_w    <= WIDTH_S;
        box_h    <= ROWS_S;
      end else begin
        box_left <= COORD_W'(x_pos);
        box_top  <= COORD_W'(y_pos);
        box_w    <= COORD_W'(rect_width);
        box_h    <= COORD_W'(rect_height);
      end
    end else if (state == S_DOT) begin
      box_left <= COORD_W'(px) + COORD_W'(col_off);
      box_top  <= COORD_W'(py) + COORD_W'(row_off);
      box_w    <= COORD_W'(scale);
      box_h    <= COORD_W'(scale);
      if (dot_row == LAST_ROW) begin
        dot_row <= '0;
        row_off <= '0;
        dot_col <= dot_col + 3'd1;
        col_off <= col_off + OFF_W'(scale);
      end else begin
        dot_row <= dot_row + 3'd1;
        row_off <= row_off + OFF_W'(scale);
      end
    end
  end

  // Clip the box to the band rows and screen width
  always_ff @(posedge clk) begin
    if (state == S_CLIP) begin
      clip_t <= (box_top < btop_s) ? btop_s : box_top;
      clip_b <= (box_b > bend_s) ? bend_s : box_b;
      clip_l <= (box_left < 0) ? '0 : box_left;
      clip_r <= (box_r > WIDTH_S) ? WIDTH_S : box_r;
    end
  end

  // Pixel sweep over the clipped box
  always_ff @(posedge clk) begin
    if (state == S_START) begin
      row       <= start_row;
      row_end   <= rel_b[ROW_W-1:0];
      col       <= clip_l[COL_W-1:0];
      col_start <= clip_l[COL_W-1:0];
      col_end   <= clip_r[COL_W-1:0];
      base      <= ADDR_W'(start_row * BAND_WIDTH);
    end else if (state == S_RUN) begin
      if (col == col_end - COL_W'(1)) begin
        col  <= col_start;
        row  <= row + ROW_W'(1);
        base <= base + ADDR_W'(BAND_WIDTH);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Read flag follows the memory latency
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_inside <= read_inside;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_RDATA) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RDATA) && (!out_valid || !out_stall)) begin
      pixel_color <= rd_inside ? rd_data : '0;
      in_band     <= rd_inside;
    end
  end

  // Checks
  a_read_then_data: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == S_RDATA))
    else $error("read data state did not follow a memory read");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_band) |-> (pixel_color == '0))
    else $error("pixel outside band returned nonzero color");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (wr.addr < ADDR_W'(STORE_DEPTH)))
    else $error("band write address out of range");

  a_sweep_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> ((col < col_end) && (row < row_end) &&
                          (col_end <= COL_W'(BAND_WIDTH))))
    else $error("sweep counters left the clipped box");

endmodule
`default_nettype wire
